[rtl/core/nbe_pkg.sv]
// ----------------------------------------------------------------------------
// N-body Euler step package
// Shared widths, reset values, codes and helper functions of the integrator.
// ----------------------------------------------------------------------------
package nbe_pkg;

  // Default build values.
  localparam int NUM_BODIES_DEF = 4;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int COORD_W       = 32;
  localparam int BODY_W        = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_MASS_REGS = 4;
  localparam int MASS_IDX_W    = 2;

  // Width of the shared divide / square-root unit and its iteration counter.
  localparam int UW     = 64;
  localparam int ITER_W = 7;

  // Register reset values.
  localparam logic [31:0] GRAV_RST = 32'd39322;
  localparam logic [31:0] DT_RST   = 32'd2621;
  localparam logic [31:0] MASS_RST [NUM_MASS_REGS] = '{
    32'd589824000, 32'd262144000, 32'd98304, 32'd104858
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAV  = 3'd0,
    REG_DT    = 3'd1,
    REG_MASS0 = 3'd2,
    REG_MASS1 = 3'd3,
    REG_MASS2 = 3'd4,
    REG_MASS3 = 3'd5
  } cfg_reg_t;

  // Request commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Operating mode of the shared unit.
  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } unit_mode_t;

  typedef struct packed {
    logic              start;
    unit_mode_t        mode;
    logic [ITER_W-1:0] iters;
  } unit_op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic [31:0] val;
    logic        clip;
  } sat_t;

  // Clip a wide signed value to 32 bits signed and report whether it clipped.
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.val  = 32'h7FFF_FFFF;
      r.clip = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.val  = 32'h8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // Magnitude of a 32-bit signed value as a 32-bit unsigned value.
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

[rtl/core/nbe_divsqrt.sv]
// ----------------------------------------------------------------------------
// Shared divide / square-root unit
// Restoring long division and digit-by-digit integer square root over one
// compare-and-subtract stage, one quotient or root bit per cycle.
// ----------------------------------------------------------------------------
module nbe_divsqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  nbe_pkg::unit_op_t          op,
  input  logic [nbe_pkg::UW-1:0]     rem0,
  input  logic [nbe_pkg::UW-1:0]     num0,
  input  logic [nbe_pkg::UW-1:0]     divisor,
  output nbe_pkg::unit_stat_t        stat,
  output logic [nbe_pkg::UW-1:0]     quo
);
  import nbe_pkg::*;

  unit_mode_t        mode_r;
  logic [UW-1:0]     rem;
  logic [UW-1:0]     num;
  logic [UW-1:0]     dvs;
  logic [UW-1:0]     q;
  logic [ITER_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [UW+1:0]     rem_sh;
  logic [UW+1:0]     trial;
  logic [UW+1:0]     diff;
  logic              ge;

  // One step: bring in the next dividend bit (or radicand bit pair) and try
  // the subtraction of the divisor (or of the trial root).
  always_comb begin
    if (mode_r == MODE_SQRT) begin
      rem_sh = {rem, num[UW-1:UW-2]};
      trial  = {q, 2'b01};
    end else begin
      rem_sh = {1'b0, rem, num[UW-1]};
      trial  = {2'b00, dvs};
    end
    ge   = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  // Iteration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (op.start) begin
        mode_r <= op.mode;
        rem    <= rem0;
        num    <= num0;
        dvs    <= divisor;
        q      <= '0;
        cnt    <= op.iters;
        busy   <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[UW-1:0] : rem_sh[UW-1:0];
        q   <= {q[UW-2:0], ge};
        num <= (mode_r == MODE_SQRT) ? {num[UW-3:0], 2'b00} : {num[UW-2:0], 1'b0};
        cnt <= cnt - ITER_W'(1);
        if (cnt == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quo       = q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    op.start |-> !busy)
    else $error("shared unit started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && !op.start && cnt == ITER_W'(1)) |=> (done && !busy))
    else $error("shared unit did not finish after its last iteration");
`endif

endmodule

[rtl/core/gravity_nbody_euler_step.sv]
// ----------------------------------------------------------------------------
// N-body gravity integrator, semi-implicit Euler, signed fixed point
// Holds position and velocity of every body and advances them one time step.
// ----------------------------------------------------------------------------
// Usage:
//   The command channel (cmd_valid / cmd_stall) takes one request at a time.
//   A load request writes one body's position and velocity and gives no
//   result. A step request computes all accelerations from the pair
//   separations first, then updates every body, and gives one result per
//   body on the result channel (res_valid / res_stall), in body order, with
//   last_body set on the final one.
//   The shared divide / square-root unit does one square root and two
//   divisions per ordered pair of separated bodies, and one division per
//   acceleration term unless the term clips early, one bit a cycle.
//   cmd_stall stays high from a step request until its last result has been
//   loaded into the output register. A stalled result holds the sequencer at
//   the next body. Reset clears the bodies to zero and loads the default
//   constants; the configuration port is always ready; the user must write it
//   only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module gravity_nbody_euler_step #(
  parameter int NUM_BODIES = nbe_pkg::NUM_BODIES_DEF,
  parameter int FRAC_BITS  = nbe_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Command channel
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  logic                                 command,
  input  logic [nbe_pkg::BODY_W-1:0]           body_index,
  input  logic signed [nbe_pkg::COORD_W-1:0]   load_pos_x,
  input  logic signed [nbe_pkg::COORD_W-1:0]   load_pos_y,
  input  logic signed [nbe_pkg::COORD_W-1:0]   load_vel_x,
  input  logic signed [nbe_pkg::COORD_W-1:0]   load_vel_y,
  // Result channel
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic [nbe_pkg::BODY_W-1:0]           out_body,
  output logic signed [nbe_pkg::COORD_W-1:0]   out_pos_x,
  output logic signed [nbe_pkg::COORD_W-1:0]   out_pos_y,
  output logic signed [nbe_pkg::COORD_W-1:0]   out_vel_x,
  output logic signed [nbe_pkg::COORD_W-1:0]   out_vel_y,
  output logic                                 saturated,
  output logic                                 coincident,
  output logic                                 last_body,
  // Configuration port
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nbe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                          cfg_data
);
  import nbe_pkg::*;

  localparam int IDX_W = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BODIES - 1);
  localparam int SUM_W = 34 + IDX_W;
  localparam logic [5:0] SH_BASE = 6'(30 - FRAC_BITS);
  localparam logic [30:0] TERM_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_LDI, S_PAIR, S_SQX, S_SQY, S_SQRT_GO, S_SQRT_W,
    S_DX_GO, S_DX_W, S_DY_GO, S_DY_W, S_GM, S_PLO, S_PHI, S_TRM,
    S_TDIV_W, S_ACC, S_NEXTJ, S_ICLIP, S_UMX, S_UVX, S_UMY, S_UVY,
    S_UMPX, S_UPX, S_UMPY, S_UPY, S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [31:0] grav;
  logic [31:0] dt;
  logic [31:0] mass [NUM_MASS_REGS];

  // Body state and per-body step results.
  logic [31:0] pos_x [NUM_BODIES];
  logic [31:0] pos_y [NUM_BODIES];
  logic [31:0] vel_x [NUM_BODIES];
  logic [31:0] vel_y [NUM_BODIES];
  logic [31:0] acc_x [NUM_BODIES];
  logic [31:0] acc_y [NUM_BODIES];
  logic        sat_b [NUM_BODIES];

  // Sequencer and pair datapath registers.
  logic [IDX_W-1:0] bi;
  logic [IDX_W-1:0] bj;
  logic             coinc;
  logic [31:0]      pix;
  logic [31:0]      piy;
  logic [30:0]      axs;
  logic [30:0]      ays;
  logic             sx;
  logic             sy;
  logic [1:0]       kk;
  logic [62:0]      d2;
  logic [31:0]      r;
  logic [30:0]      ux;
  logic [30:0]      uy;
  logic [63:0]      pgm;
  logic [63:0]      prod;
  logic [62:0]      plo;
  logic [30:0]      term;
  logic             axis;
  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;
  logic             sat_cur;
  logic [31:0]      vx_r;
  logic [31:0]      vy_r;
  logic [31:0]      px_r;
  logic [31:0]      py_r;
  logic             usat;

  // Combinational signals.
  logic [IDX_W-1:0]  rd_idx;
  logic [31:0]       rd_px;
  logic [31:0]       rd_py;
  logic [32:0]       dx;
  logic [32:0]       dy;
  logic [32:0]       ax;
  logic [32:0]       ay;
  logic [1:0]        kk_c;
  logic [31:0]       mass_j;
  logic [30:0]       u_sel;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_out;
  logic [5:0]        sh;
  logic [95:0]       full;
  logic [95:0]       nsh;
  logic              tsat;
  logic [SUM_W-1:0]  addend;
  sat_t              clx;
  sat_t              cly;
  logic [31:0]       upd_base;
  logic              upd_neg;
  logic [63:0]       upd_sc;
  logic [63:0]       upd_wide;
  sat_t              upd;
  logic [IDX_W-1:0]  ld_idx;

  unit_op_t          unit_op;
  unit_stat_t        unit_stat;
  logic [UW-1:0]     unit_rem0;
  logic [UW-1:0]     unit_num;
  logic [UW-1:0]     unit_dvs;
  logic [UW-1:0]     unit_quo;

  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign ld_idx    = IDX_W'(body_index);

  // Body state read port: body j while forming separations, body i otherwise.
  assign rd_idx = (state == S_PAIR) ? bj : bi;
  assign rd_px  = pos_x[rd_idx];
  assign rd_py  = pos_y[rd_idx];

  // Separation, magnitudes and the range shift that brings both below 2^31.
  always_comb begin
    dx   = {rd_px[31], rd_px} - {pix[31], pix};
    dy   = {rd_py[31], rd_py} - {piy[31], piy};
    ax   = dx[32] ? (~dx + 33'd1) : dx;
    ay   = dy[32] ? (~dy + 33'd1) : dy;
    if (ax[32] || ay[32]) begin
      kk_c = 2'd2;
    end else if (ax[31] || ay[31]) begin
      kk_c = 2'd1;
    end else begin
      kk_c = 2'd0;
    end
  end

  assign mass_j = (int'(bj) < NUM_MASS_REGS) ? mass[MASS_IDX_W'(bj)] : 32'd0;
  assign u_sel  = axis ? uy : ux;

  // Shared multiplier operand selection.
  always_comb begin
    case (state)
      S_SQX:   begin mul_a = 32'(axs);         mul_b = 32'(axs); end
      S_SQY:   begin mul_a = 32'(ays);         mul_b = 32'(ays); end
      S_GM:    begin mul_a = grav;             mul_b = mass_j; end
      S_PLO:   begin mul_a = pgm[31:0];        mul_b = 32'(u_sel); end
      S_PHI:   begin mul_a = pgm[63:32];       mul_b = 32'(u_sel); end
      S_UMX:   begin mul_a = mag32(acc_x[bi]); mul_b = dt; end
      S_UMY:   begin mul_a = mag32(acc_y[bi]); mul_b = dt; end
      S_UMPX:  begin mul_a = mag32(vx_r);      mul_b = dt; end
      S_UMPY:  begin mul_a = mag32(vy_r);      mul_b = dt; end
      default: begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  // Scaled product of mass factor and unit component, and the early test
  // whether the quotient by d2 reaches 2^31.
  always_comb begin
    sh   = SH_BASE + {3'b000, kk, 1'b0};
    full = (96'(prod) << 32) + 96'(plo);
    nsh  = full >> sh;
    tsat = (nsh[95:31] >= 65'(d2));
  end

  // Signed term and acceleration clipping.
  always_comb begin
    addend = (axis ? sy : sx) ? (~SUM_W'(term) + SUM_W'(1)) : SUM_W'(term);
    clx    = sat32(64'(signed'(sum_x)));
    cly    = sat32(64'(signed'(sum_y)));
  end

  // Update adder: base + trunc(value * dt / 2^FRAC_BITS), then clip.
  always_comb begin
    case (state)
      S_UVX:   begin upd_base = vel_x[bi]; upd_neg = acc_x[bi][31]; end
      S_UVY:   begin upd_base = vel_y[bi]; upd_neg = acc_y[bi][31]; end
      S_UPX:   begin upd_base = pos_x[bi]; upd_neg = vx_r[31]; end
      S_UPY:   begin upd_base = pos_y[bi]; upd_neg = vy_r[31]; end
      default: begin upd_base = '0;        upd_neg = 1'b0; end
    endcase
    upd_sc   = prod >> FRAC_BITS;
    upd_wide = {{32{upd_base[31]}}, upd_base} + (upd_neg ? (~upd_sc + 64'd1) : upd_sc);
    upd      = sat32(signed'(upd_wide));
  end

  // Requests to the shared divide / square-root unit.
  always_comb begin
    unit_op.start = 1'b0;
    unit_op.mode  = MODE_DIV;
    unit_op.iters = ITER_W'(64);
    unit_rem0     = '0;
    unit_num      = '0;
    unit_dvs      = '0;
    case (state)
      S_SQRT_GO: begin
        unit_op.start = 1'b1;
        unit_op.mode  = MODE_SQRT;
        unit_op.iters = ITER_W'(32);
        unit_num      = 64'(d2);
      end
      S_DX_GO: begin
        unit_op.start = 1'b1;
        unit_num      = 64'(axs) << 30;
        unit_dvs      = 64'(r);
      end
      S_DY_GO: begin
        unit_op.start = 1'b1;
        unit_num      = 64'(ays) << 30;
        unit_dvs      = 64'(r);
      end
      S_TRM: begin
        unit_op.start = !tsat;
        unit_op.iters = ITER_W'(31);
        unit_rem0     = nsh[94:31];
        unit_num      = {nsh[30:0], 33'd0};
        unit_dvs      = 64'(d2);
      end
      default: begin
      end
    endcase
  end

  nbe_divsqrt u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .op      (unit_op),
    .rem0    (unit_rem0),
    .num0    (unit_num),
    .divisor (unit_dvs),
    .stat    (unit_stat),
    .quo     (unit_quo)
  );

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      coinc     <= 1'b0;
      grav      <= GRAV_RST;
      dt        <= DT_RST;
      for (int m = 0; m < NUM_MASS_REGS; m++) begin
        mass[m] <= MASS_RST[m];
      end
      for (int b = 0; b < NUM_BODIES; b++) begin
        pos_x[b] <= '0;
        pos_y[b] <= '0;
        vel_x[b] <= '0;
        vel_y[b] <= '0;
      end
    end else begin
      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GRAV:  grav    <= cfg_data;
          REG_DT:    dt      <= cfg_data;
          REG_MASS0: mass[0] <= cfg_data;
          REG_MASS1: mass[1] <= cfg_data;
          REG_MASS2: mass[2] <= cfg_data;
          REG_MASS3: mass[3] <= cfg_data;
          default: begin
          end
        endcase
      end

      // Output register drains when the receiver takes the result; the emit
      // state reloads it itself.
      if (res_valid && !res_stall && state != S_EMIT) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (command == CMD_STEP) begin
              bi    <= '0;
              coinc <= 1'b0;
              state <= S_LDI;
            end else if (int'(body_index) < NUM_BODIES) begin
              pos_x[ld_idx] <= load_pos_x;
              pos_y[ld_idx] <= load_pos_y;
              vel_x[ld_idx] <= load_vel_x;
              vel_y[ld_idx] <= load_vel_y;
            end
          end
        end
        S_LDI: begin
          pix     <= rd_px;
          piy     <= rd_py;
          bj      <= '0;
          sum_x   <= '0;
          sum_y   <= '0;
          sat_cur <= 1'b0;
          state   <= S_PAIR;
        end
        S_PAIR: begin
          if (bj == bi) begin
            state <= S_NEXTJ;
          end else if (dx == '0 && dy == '0) begin
            coinc <= 1'b1;
            state <= S_NEXTJ;
          end else begin
            axs   <= 31'(ax >> kk_c);
            ays   <= 31'(ay >> kk_c);
            sx    <= dx[32];
            sy    <= dy[32];
            kk    <= kk_c;
            state <= S_SQX;
          end
        end
        S_SQX: begin
          prod  <= mul_out;
          state <= S_SQY;
        end
        S_SQY: begin
          d2    <= 63'(prod) + 63'(mul_out);
          state <= S_SQRT_GO;
        end
        S_SQRT_GO: state <= S_SQRT_W;
        S_SQRT_W: begin
          if (unit_stat.done) begin
            r     <= unit_quo[31:0];
            state <= S_DX_GO;
          end
        end
        S_DX_GO: state <= S_DX_W;
        S_DX_W: begin
          if (unit_stat.done) begin
            ux    <= unit_quo[30:0];
            state <= S_DY_GO;
          end
        end
        S_DY_GO: state <= S_DY_W;
        S_DY_W: begin
          if (unit_stat.done) begin
            uy    <= unit_quo[30:0];
            state <= S_GM;
          end
        end
        S_GM: begin
          pgm   <= mul_out;
          axis  <= 1'b0;
          state <= S_PLO;
        end
        S_PLO: begin
          plo   <= 63'(mul_out);
          state <= S_PHI;
        end
        S_PHI: begin
          prod  <= mul_out;
          state <= S_TRM;
        end
        S_TRM: begin
          if (tsat) begin
            term    <= TERM_MAX;
            sat_cur <= 1'b1;
            state   <= S_ACC;
          end else begin
            state   <= S_TDIV_W;
          end
        end
        S_TDIV_W: begin
          if (unit_stat.done) begin
            term  <= unit_quo[30:0];
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (!axis) begin
            sum_x <= sum_x + addend;
            axis  <= 1'b1;
            state <= S_PLO;
          end else begin
            sum_y <= sum_y + addend;
            state <= S_NEXTJ;
          end
        end
        S_NEXTJ: begin
          if (bj == LAST_IDX) begin
            state <= S_ICLIP;
          end else begin
            bj    <= bj + IDX_W'(1);
            state <= S_PAIR;
          end
        end
        S_ICLIP: begin
          acc_x[bi] <= clx.val;
          acc_y[bi] <= cly.val;
          sat_b[bi] <= sat_cur | clx.clip | cly.clip;
          if (bi == LAST_IDX) begin
            bi    <= '0;
            state <= S_UMX;
          end else begin
            bi    <= bi + IDX_W'(1);
            state <= S_LDI;
          end
        end
        S_UMX: begin
          prod  <= mul_out;
          usat  <= sat_b[bi];
          state <= S_UVX;
        end
        S_UVX: begin
          vx_r  <= upd.val;
          usat  <= usat | upd.clip;
          state <= S_UMY;
        end
        S_UMY: begin
          prod  <= mul_out;
          state <= S_UVY;
        end
        S_UVY: begin
          vy_r  <= upd.val;
          usat  <= usat | upd.clip;
          state <= S_UMPX;
        end
        S_UMPX: begin
          prod  <= mul_out;
          state <= S_UPX;
        end
        S_UPX: begin
          px_r  <= upd.val;
          usat  <= usat | upd.clip;
          state <= S_UMPY;
        end
        S_UMPY: begin
          prod  <= mul_out;
          state <= S_UPY;
        end
        S_UPY: begin
          // Position y is final here; the result goes out in the next state.
          py_r      <= upd.val;
          usat      <= usat | upd.clip;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_valid || !res_stall) begin
            pos_x[bi]  <= px_r;
            pos_y[bi]  <= py_r;
            vel_x[bi]  <= vx_r;
            vel_y[bi]  <= vy_r;
            out_body   <= BODY_W'(bi);
            out_pos_x  <= px_r;
            out_pos_y  <= py_r;
            out_vel_x  <= vx_r;
            out_vel_y  <= vy_r;
            saturated  <= usat;
            coincident <= coinc;
            last_body  <= (bi == LAST_IDX);
            res_valid  <= 1'b1;
            if (bi == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              bi    <= bi + IDX_W'(1);
              state <= S_UMX;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_pair_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQX) |-> (bj != bi))
    else $error("pair arithmetic started on a body with itself");

  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DX_GO) |-> (r != '0))
    else $error("zero separation root reached the unit divisions");

  a_div_precond: assert property (@(posedge clk) disable iff (rst)
    (unit_op.start && unit_op.mode == MODE_DIV) |-> (unit_rem0 < unit_dvs))
    else $error("division started with a partial remainder not below the divisor");

  a_idle_unit_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !unit_stat.busy)
    else $error("shared unit busy while the sequencer is idle");
`endif

endmodule

[test/tb_gravity_nbody_euler_step.sv]
// ----------------------------------------------------------------------------
// Testbench for the N-body gravity Euler step integrator
// Loads body states, advances time steps under several register settings,
// and checks every reported body state against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_gravity_nbody_euler_step;
  import nbe_pkg::*;

  localparam int NB          = 4;
  localparam int FB          = 16;
  localparam int IDLE_LIMIT  = 40000;
  localparam int HOLD_CYCLES = 4000;

  typedef struct {
    logic [1:0]  body;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic        sat;
    logic        coinc;
    logic        last;
  } body_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic        command = CMD_LOAD;
  logic [1:0]  body_index = '0;
  logic [31:0] load_pos_x = '0;
  logic [31:0] load_pos_y = '0;
  logic [31:0] load_vel_x = '0;
  logic [31:0] load_vel_y = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [1:0]  out_body;
  logic [31:0] out_pos_x;
  logic [31:0] out_pos_y;
  logic [31:0] out_vel_x;
  logic [31:0] out_vel_y;
  logic        saturated;
  logic        coincident;
  logic        last_body;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor state: registers and body states.
  logic [31:0] grav_q;
  logic [31:0] dt_q;
  logic [31:0] mass_q [NB];
  logic signed [31:0] body_px [NB];
  logic signed [31:0] body_py [NB];
  logic signed [31:0] body_vx [NB];
  logic signed [31:0] body_vy [NB];

  body_res_t expected_bodies [$];
  int errors = 0;
  int stall_mode = 0;
  bit hold_req = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  gravity_nbody_euler_step dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .command(command),
    .body_index(body_index), .load_pos_x(load_pos_x), .load_pos_y(load_pos_y),
    .load_vel_x(load_vel_x), .load_vel_y(load_vel_y),
    .res_valid(res_valid), .res_stall(res_stall), .out_body(out_body),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_vel_x(out_vel_x),
    .out_vel_y(out_vel_y), .saturated(saturated), .coincident(coincident),
    .last_body(last_body),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Integer square root, floor.
  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Magnitude of one pair term, clipped to 31 bits.
  function automatic longint pair_term(input logic [63:0] p, input logic [63:0] u,
                                       input int s, input logic [63:0] d,
                                       inout bit flag);
    logic [127:0] q;
    q = ({64'd0, p} * {64'd0, u}) >> s;
    q = q / {64'd0, d};
    if (q > 128'h7FFF_FFFF) begin
      flag = 1;
      return 64'h7FFF_FFFF;
    end
    return longint'(q[63:0]);
  endfunction

  function automatic longint clip32(input longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Product with the time step, rounded toward zero.
  function automatic longint scale_dt(input longint a);
    logic [63:0] m;
    m = (a < 0) ? -a : a;
    m = (m * {32'd0, dt_q}) >> FB;
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Advance all bodies one step and queue the results that should follow.
  function automatic void advance_bodies();
    longint acc_x [NB];
    longint acc_y [NB];
    bit sat [NB];
    bit coinc;
    longint dx, dy, sx, sy, nvx, nvy, npx, npy;
    logic [63:0] ax, ay, d2, r, ux, uy, p;
    int k;
    body_res_t e;
    coinc = 0;
    for (int i = 0; i < NB; i++) begin
      sx = 0;
      sy = 0;
      sat[i] = 0;
      for (int j = 0; j < NB; j++) begin
        if (j == i) continue;
        dx = longint'(body_px[j]) - longint'(body_px[i]);
        dy = longint'(body_py[j]) - longint'(body_py[i]);
        if (dx == 0 && dy == 0) begin
          coinc = 1;
          continue;
        end
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        k = 0;
        while (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
          ax = ax >> 1;
          ay = ay >> 1;
          k++;
        end
        d2 = ax * ax + ay * ay;
        if (d2 == 0) begin
          coinc = 1;
          continue;
        end
        r = isqrt(d2);
        ux = (ax << 30) / r;
        uy = (ay << 30) / r;
        p = {32'd0, grav_q} * {32'd0, mass_q[j]};
        dx = (dx < 0) ? -pair_term(p, ux, 30 + 2 * k - FB, d2, sat[i])
                      : pair_term(p, ux, 30 + 2 * k - FB, d2, sat[i]);
        dy = (dy < 0) ? -pair_term(p, uy, 30 + 2 * k - FB, d2, sat[i])
                      : pair_term(p, uy, 30 + 2 * k - FB, d2, sat[i]);
        sx += dx;
        sy += dy;
      end
      acc_x[i] = clip32(sx, sat[i]);
      acc_y[i] = clip32(sy, sat[i]);
    end
    for (int i = 0; i < NB; i++) begin
      nvx = clip32(longint'(body_vx[i]) + scale_dt(acc_x[i]), sat[i]);
      nvy = clip32(longint'(body_vy[i]) + scale_dt(acc_y[i]), sat[i]);
      npx = clip32(longint'(body_px[i]) + scale_dt(nvx), sat[i]);
      npy = clip32(longint'(body_py[i]) + scale_dt(nvy), sat[i]);
      body_vx[i] = nvx[31:0];
      body_vy[i] = nvy[31:0];
      body_px[i] = npx[31:0];
      body_py[i] = npy[31:0];
      e.body  = i[1:0];
      e.pos_x = body_px[i];
      e.pos_y = body_py[i];
      e.vel_x = body_vx[i];
      e.vel_y = body_vy[i];
      e.sat   = sat[i];
      e.coinc = coinc;
      e.last  = (i == NB - 1);
      expected_bodies.push_back(e);
    end
  endfunction

  // Send one request; unless no_gap is set, the sender may idle between bursts of random length.
  task automatic send_req(input logic cmd, input logic [1:0] idx,
                          input logic [31:0] px, input logic [31:0] py,
                          input logic [31:0] vx, input logic [31:0] vy,
                          input bit no_gap = 0);
    bit acc;
    int gap;
    gap = 0;
    if (!no_gap) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command    <= cmd;
    body_index <= idx;
    load_pos_x <= px;
    load_pos_y <= py;
    load_vel_x <= vx;
    load_vel_y <= vy;
    cmd_valid  <= 1'b1;
    do begin
      @(negedge clk);
      acc = !cmd_stall;
      @(posedge clk);
    end while (!acc);
    if (cmd == CMD_STEP) begin
      advance_bodies();
    end else begin
      body_px[idx] = px;
      body_py[idx] = py;
      body_vx[idx] = vx;
      body_vy[idx] = vy;
    end
  endtask

  task automatic load_body(input logic [1:0] idx, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] vx,
                           input logic [31:0] vy);
    send_req(CMD_LOAD, idx, px, py, vx, vy);
  endtask

  task automatic step_bodies();
    send_req(CMD_STEP, $urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom);
  endtask

  // Stop offering requests and wait until every expected body state is in.
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (expected_bodies.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    bit acc;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    case (idx)
      REG_GRAV:  grav_q = val;
      REG_DT:    dt_q = val;
      REG_MASS0: mass_q[0] = val;
      REG_MASS1: mass_q[1] = val;
      REG_MASS2: mass_q[2] = val;
      REG_MASS3: mass_q[3] = val;
      default: ;
    endcase
  endtask

  // Write the whole register set while the block is idle.
  task automatic set_config(input logic [31:0] g, input logic [31:0] dt,
                            input logic [31:0] m0, input logic [31:0] m1,
                            input logic [31:0] m2, input logic [31:0] m3);
    write_reg(REG_GRAV, g);
    write_reg(REG_DT, dt);
    write_reg(REG_MASS0, m0);
    write_reg(REG_MASS1, m1);
    write_reg(REG_MASS2, m2);
    write_reg(REG_MASS3, m3);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinate with a mix of magnitudes: near, far, extreme and zero.
  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom;
      1: v = ($urandom_range(0, 1)) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                    : 32'h8000_0000 + $urandom_range(0, 3);
      2: v = '0;
      3, 4: v = $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
      default: v = $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_vel();
    return ($urandom_range(0, 4) == 0) ? $urandom
                                       : $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
  endfunction

  // Steps from reset: every pair coincides.
  task automatic test_reset_state();
    step_bodies();
    wait_drained();
  endtask

  // Directed layouts: spread bodies, extreme corners, coincident pairs.
  task automatic test_directed();
    load_body(0, 32'd0, 32'd0, 32'd0, 32'd0);
    load_body(1, 32'h000A_0000, 32'd0, 32'd0, 32'h0001_0000);
    load_body(2, 32'd0, 32'hFFF6_0000, 32'hFFFF_8000, 32'd0);
    load_body(3, 32'h0003_0000, 32'h0004_0000, 32'd0, 32'd0);
    step_bodies();
    step_bodies();
    // Opposite corners force the wide separation shift.
    load_body(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    load_body(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    load_body(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
    load_body(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    step_bodies();
    // Two bodies at one point, and two close together, one unit apart on each axis.
    load_body(0, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0);
    load_body(1, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0);
    load_body(2, 32'd1, 32'd0, 32'd0, 32'd0);
    load_body(3, 32'd0, 32'd1, 32'd0, 32'd0);
    step_bodies();
    step_bodies();
    wait_drained();
  endtask

  // Register extremes, unused register indexes, and random body states.
  task automatic test_config_extremes();
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    for (int b = 0; b < NB; b++) load_body(b, rand_coord(), rand_coord(), rand_vel(), rand_vel());
    step_bodies();
    wait_drained();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    step_bodies();
    load_body(2, 32'h0000_0100, 32'hFFFF_FF00, 32'd0, 32'd0);
    step_bodies();
    wait_drained();
  endtask

  // Random phases of loads and steps under changing register settings.
  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: set_config(GRAV_RST, DT_RST, MASS_RST[0], MASS_RST[1], MASS_RST[2], MASS_RST[3]);
        1: set_config($urandom, $urandom_range(0, 32'h0002_0000), $urandom, $urandom,
                      $urandom, $urandom);
        default: set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      stall_mode = ph % 3;
      for (int n = 0; n < 28; n++) begin
        if ($urandom_range(0, 9) < 6)
          load_body($urandom_range(0, 3), rand_coord(), rand_coord(), rand_vel(), rand_vel());
        else
          step_bodies();
      end
      wait_drained();
    end
  endtask

  // Long receiver hold while requests keep coming, then a full pause.
  task automatic test_backpressure();
    stall_mode = 1;
    hold_req = 1;
    step_bodies();
    for (int n = 0; n < 6; n++) begin
      if (n % 2) step_bodies();
      else send_req(CMD_LOAD, n[1:0], rand_coord(), rand_coord(), rand_vel(), rand_vel(), 1);
    end
    wait_drained();
    stall_mode = 0;
    step_bodies();
    wait_drained();
  endtask

  // Receiver stall pattern, with an occasional long hold counted here.
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        hold_req = 0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 99) < 35);
        default: res_stall <= ((cyc % 7) < 3);
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
    end
  endfunction

  // Result checker and watchdog; values seen at the falling edge hold at the next rise.
  always @(negedge clk) begin
    body_res_t e;
    if (!rst) begin
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
      if (res_valid && !res_stall) begin
        if (expected_bodies.size() == 0) begin
          errors++;
          $display("%0t: unexpected body result, actual body %0d", $time, out_body);
        end else begin
          e = expected_bodies.pop_front();
          check_field("out_body", e.body, out_body);
          check_field("out_pos_x", e.pos_x, out_pos_x);
          check_field("out_pos_y", e.pos_y, out_pos_y);
          check_field("out_vel_x", e.vel_x, out_vel_x);
          check_field("out_vel_y", e.vel_y, out_vel_y);
          check_field("saturated", e.sat, saturated);
          check_field("coincident", e.coinc, coincident);
          check_field("last_body", e.last, last_body);
        end
      end
    end
  end

  initial begin
    grav_q = GRAV_RST;
    dt_q = DT_RST;
    for (int b = 0; b < NB; b++) begin
      mass_q[b] = MASS_RST[b];
      body_px[b] = '0;
      body_py[b] = '0;
      body_vx[b] = '0;
      body_vy[b] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_config_extremes();
    test_random_phases();
    test_backpressure();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_bodies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
